// ----- sv/mwc_seed_search_defines.svh -----
// Assertion macros for the multiply-with-carry seed search block.
// Included by the top level; expects signals named clock and reset in scope.
`ifndef MWC_SEED_SEARCH_DEFINES_SVH
`define MWC_SEED_SEARCH_DEFINES_SVH

// same-cycle implication, off during reset
`define MWC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off during reset
`define MWC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/mwc_pkg.sv -----
// Constants and types of the multiply-with-carry seed search block.
// No dependencies; used by the top level.
`timescale 1ns / 1ps

package mwc_pkg;

   localparam logic [31:0] MWC_MUL         = 32'h6AC6_90C5;
   localparam logic [31:0] MWC_CARRY_RESET = 32'h0000_029A;

   // low word of floor(2^64 / MWC_MUL); the two bits above it are 2'b10
   localparam logic [31:0] MWC_RECIP_FRAC  = 32'(64'hFFFF_FFFF_FFFF_FFFF / 64'(MWC_MUL));

   function automatic logic [31:0] mwc_mul_inverse();
      logic [31:0] inv;
      inv = MWC_MUL;
      for (int k = 0; k < 5; k++) begin
         inv = inv * (32'd2 - MWC_MUL * inv);
      end
      return inv;
   endfunction

   localparam logic [31:0] MWC_INV = mwc_mul_inverse();

   typedef enum logic [3:0] {
      S_IDLE,
      S_EST_LO,
      S_REM_LO,
      S_EST_HI,
      S_REM_HI,
      S_WIN,
      S_INV,
      S_STEP1,
      S_STEP2,
      S_CHECK,
      S_DONE
   } mwc_state_type;

endpackage

// ----- sv/mwc_req_if.sv -----
// Request channel of the seed search: seed range and target carry.
// Valid/ready handshake; no package dependency.
`timescale 1ns / 1ps

interface mwc_req_if #(
   parameter int SEED_BITS = 31
) ();
   logic                 valid;
   logic                 ready;
   logic [SEED_BITS-1:0] range_low;
   logic [SEED_BITS-1:0] range_high;
   logic [31:0]          target;

   modport source (output valid, output range_low, output range_high, output target,
                   input ready);
   modport sink   (input valid, input range_low, input range_high, input target,
                   output ready);
endinterface

// ----- sv/mwc_rsp_if.sv -----
// Response channel of the seed search: found flag and smallest seed.
// Valid/ready handshake; no package dependency.
`timescale 1ns / 1ps

interface mwc_rsp_if #(
   parameter int SEED_BITS = 31
) ();
   logic                 valid;
   logic                 ready;
   logic                 found;
   logic [SEED_BITS-1:0] seed;

   modport source (output valid, output found, output seed, input ready);
   modport sink   (input valid, input found, input seed, output ready);
endinterface

// ----- sv/mwc_seed_search.sv -----
// Seed search top level; depends on mwc_pkg, the channel interfaces and the defines header.
// An empty range goes straight to the response; else reciprocal division, one window
// check, then up to five candidates (S_INV, S_STEP1, and S_STEP2 and S_CHECK if in
// range), all through one shared 32x32 multiply-add unit. One item at a time: the next
// is accepted in the cycle after the result loads; a waiting result holds the next.
// Synchronous active-high reset: idle, no response pending, carry back to 0x29A.
`timescale 1ns / 1ps
`include "mwc_seed_search_defines.svh"

module mwc_seed_search #(
   parameter int SEED_BITS = 31
) (
   input  logic        clock,
   input  logic        reset,
   mwc_req_if.sink     req_ch,
   mwc_rsp_if.source   rsp_ch,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);
   import mwc_pkg::*;

   mwc_state_type        state_ff, state_in;
   logic [31:0]          carry_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_found_ff, rsp_found_in;
   logic [SEED_BITS-1:0] rsp_seed_ff, rsp_seed_in;

   logic [SEED_BITS-1:0] lo_ff, lo_in;
   logic [SEED_BITS-1:0] hi_ff, hi_in;
   logic [31:0]          t_ff, t_in;
   logic [33:0]          q_ff, q_in;
   logic [33:0]          v_ff, v_in;
   logic [31:0]          vhi_ff, vhi_in;
   logic [63:0]          prod_ff, prod_in;
   logic [31:0]          s_ff, s_in;
   logic                 found_ff, found_in;
   logic [SEED_BITS-1:0] best_ff, best_in;

   logic [31:0] mul_a, mul_b, mul_add;
   logic [63:0] mul_out;
   logic        est_hi;
   logic [31:0] est_a;
   logic [33:0] q_est;
   logic [31:0] rem;
   logic        rem_ge;
   logic [33:0] q_fix;
   logic [33:0] v_inc;
   logic        s_in_range;
   logic        accept;

   assign mul_out = 64'(mul_a) * 64'(mul_b) + 64'(mul_add);

   assign est_hi = (state_ff == S_EST_HI) || (state_ff == S_REM_HI);
   assign est_a  = est_hi ? t_ff + 32'd1 : t_ff - 32'd1;
   assign q_est  = {1'b0, est_a, 1'b0} + 34'(prod_ff[63:32]);
   assign rem    = 32'd0 - prod_ff[31:0];
   assign rem_ge = rem >= MWC_MUL;
   assign q_fix  = q_ff + 34'(rem_ge);

   assign v_inc      = v_ff + 34'd1;
   assign s_in_range = (prod_ff[31:0] >= 32'(lo_ff)) && (prod_ff[31:0] <= 32'(hi_ff));

   assign req_ch.ready = state_ff == S_IDLE;
   assign accept       = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.found = rsp_found_ff;
   assign rsp_ch.seed  = rsp_seed_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_found_in = rsp_found_ff;
      rsp_seed_in  = rsp_seed_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      t_in         = t_ff;
      q_in         = q_ff;
      v_in         = v_ff;
      vhi_in       = vhi_ff;
      prod_in      = prod_ff;
      s_in         = s_ff;
      found_in     = found_ff;
      best_in      = best_ff;
      mul_a        = '0;
      mul_b        = '0;
      mul_add      = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               lo_in    = req_ch.range_low;
               hi_in    = req_ch.range_high;
               t_in     = req_ch.target;
               found_in = 1'b0;
               best_in  = '0;
               state_in = (req_ch.range_low > req_ch.range_high) ? S_DONE : S_EST_LO;
            end
         end
         S_EST_LO: begin
            mul_a    = est_a;
            mul_b    = MWC_RECIP_FRAC;
            prod_in  = mul_out;
            state_in = S_REM_LO;
         end
         S_REM_LO: begin
            q_in     = q_est;
            mul_a    = q_est[31:0];
            mul_b    = MWC_MUL;
            prod_in  = mul_out;
            state_in = S_EST_HI;
         end
         S_EST_HI: begin
            v_in     = (t_ff == 32'd0) ? 34'd0 : q_fix + 34'd1;
            mul_a    = est_a;
            mul_b    = MWC_RECIP_FRAC;
            prod_in  = mul_out;
            state_in = S_REM_HI;
         end
         S_REM_HI: begin
            q_in     = q_est;
            mul_a    = q_est[31:0];
            mul_b    = MWC_MUL;
            prod_in  = mul_out;
            state_in = S_WIN;
         end
         S_WIN: begin
            priority if (t_ff >= MWC_MUL) begin
               vhi_in = 32'hFFFF_FFFF;
            end else if (rem == 32'd0) begin
               vhi_in = q_ff[31:0] - 32'd1;
            end else if (rem > MWC_MUL) begin
               vhi_in = q_ff[31:0] + 32'd1;
            end else begin
               vhi_in = q_ff[31:0];
            end
            state_in = (v_ff > 34'(vhi_in)) ? S_DONE : S_INV;
         end
         S_INV: begin
            mul_a    = v_ff[31:0] - carry_ff;
            mul_b    = MWC_INV;
            prod_in  = mul_out;
            state_in = S_STEP1;
         end
         S_STEP1: begin
            s_in = prod_ff[31:0];
            if (s_in_range) begin
               mul_a    = prod_ff[31:0];
               mul_b    = MWC_MUL;
               mul_add  = carry_ff;
               prod_in  = mul_out;
               state_in = S_STEP2;
            end else begin
               v_in     = v_inc;
               state_in = (v_inc > 34'(vhi_ff)) ? S_DONE : S_INV;
            end
         end
         S_STEP2: begin
            mul_a    = prod_ff[31:0];
            mul_b    = MWC_MUL;
            mul_add  = prod_ff[63:32];
            prod_in  = mul_out;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if ((prod_ff[63:32] == t_ff) && (!found_ff || (s_ff < 32'(best_ff)))) begin
               found_in = 1'b1;
               best_in  = s_ff[SEED_BITS-1:0];
            end
            v_in     = v_inc;
            state_in = (v_inc > 34'(vhi_ff)) ? S_DONE : S_INV;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = found_ff;
               rsp_seed_in  = found_ff ? best_ff : '0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         carry_ff     <= MWC_CARRY_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            carry_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_found_ff <= rsp_found_in;
      rsp_seed_ff  <= rsp_seed_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      t_ff         <= t_in;
      q_ff         <= q_in;
      v_ff         <= v_in;
      vhi_ff       <= vhi_in;
      prod_ff      <= prod_in;
      s_ff         <= s_in;
      found_ff     <= found_in;
      best_ff      <= best_in;
   end

   `MWC_ASSERT_NOW(a_best_in_range, (state_ff == S_DONE) && found_ff,
      (best_ff >= lo_ff) && (best_ff <= hi_ff), "found seed outside the range")
   `MWC_ASSERT_NOW(a_miss_zero_seed, rsp_valid_ff && !rsp_found_ff,
      rsp_seed_ff == '0, "miss with nonzero seed")
   `MWC_ASSERT_NOW(a_cand_in_window, state_ff == S_INV,
      v_ff <= 34'(vhi_ff), "candidate past window end")
   `MWC_ASSERT_NEXT(a_accept_starts, accept,
      (state_ff == S_EST_LO) || (state_ff == S_DONE), "accepted item did not start")

endmodule
